[src/olt_pkg.sv]
// ----------------------------------------------------------------------------
// olt_pkg
// Types, codes and helpers shared by the order lifecycle table.
// ----------------------------------------------------------------------------
package olt_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	typedef enum logic [3:0] {
		CMD_SUBMIT    = 4'd0,
		CMD_CANCEL    = 4'd1,
		CMD_REPLACE   = 4'd2,
		CMD_ACCEPTED  = 4'd3,
		CMD_REJECTED  = 4'd4,
		CMD_CANCELLED = 4'd5,
		CMD_REPLACED  = 4'd6,
		CMD_TRADE     = 4'd7,
		CMD_QUERY     = 4'd8
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_OK      = 3'd0,
		KIND_REFUSED = 3'd1,
		KIND_UPDATE  = 3'd2,
		KIND_FILL    = 3'd3,
		KIND_FOUND   = 3'd4,
		KIND_MISSING = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		ST_PENDINGNEW = 3'd0,
		ST_LIVE       = 3'd1,
		ST_PARTFILLED = 3'd2,
		ST_FILLED     = 3'd3,
		ST_CANCELLED  = 3'd4,
		ST_REPLACED   = 3'd5,
		ST_REJECTED   = 3'd6
	} ord_state_t;

	typedef enum logic [1:0] {
		PEND_NONE    = 2'd0,
		PEND_CANCEL  = 2'd1,
		PEND_REPLACE = 2'd2
	} pend_t;

	typedef enum logic [1:0] {
		CFG_FILL_EN   = 2'd0,
		CFG_UPDATE_EN = 2'd1,
		CFG_ERR_CODE  = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_EXEC,
		FSM_EXEC2,
		FSM_REPL_WR,
		FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic [3:0]         command;
		logic [31:0]        order_id;
		logic [31:0]        new_order_id;
		logic [31:0]        exchange_ref;
		logic [31:0]        instrument;
		logic               buy_sell;
		logic signed [31:0] limit_price;
		logic [31:0]        amount;
		logic [31:0]        left_amount;
		logic [7:0]         order_attrs;
		logic [3:0]         reason_in;
		logic               send_ok;
	} req_t;

	typedef struct packed {
		logic               valid;
		logic [31:0]        tag;
		logic [31:0]        xref;
		logic [31:0]        instr;
		logic               side;
		logic signed [31:0] price;
		logic [31:0]        amount;
		logic [31:0]        left;
		logic [7:0]         attrs;
		logic [2:0]         status;
		logic [1:0]         pending;
		logic [3:0]         reason;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [2:0]         kind;
		logic [31:0]        order_id;
		logic [2:0]         order_state;
		logic [1:0]         pending;
		logic [31:0]        exchange_ref;
		logic [31:0]        instrument;
		logic               side;
		logic signed [31:0] price;
		logic [31:0]        amount;
		logic [31:0]        left;
		logic [3:0]         last_reason;
	} res_t;

	function automatic res_t mk_short(input kind_t k, input logic [31:0] id);
		res_t r;
		r          = '0;
		r.kind     = k;
		r.order_id = id;
		return r;
	endfunction

	function automatic res_t mk_entry(input kind_t k, input entry_t e);
		res_t r;
		r.kind         = k;
		r.order_id     = e.tag;
		r.order_state  = e.status;
		r.pending      = e.pending;
		r.exchange_ref = e.xref;
		r.instrument   = e.instr;
		r.side         = e.side;
		r.price        = e.price;
		r.amount       = e.amount;
		r.left         = e.left;
		r.last_reason  = e.reason;
		return r;
	endfunction

	function automatic entry_t mk_new(input logic [31:0] id, input logic [31:0] instr,
		input logic side, input logic signed [31:0] price, input logic [31:0] qty,
		input logic [7:0] attrs);
		entry_t e;
		e         = '0;
		e.valid   = 1'b1;
		e.tag     = id;
		e.instr   = instr;
		e.side    = side;
		e.price   = price;
		e.amount  = qty;
		e.left    = qty;
		e.attrs   = attrs;
		e.status  = ST_PENDINGNEW;
		e.pending = PEND_NONE;
		return e;
	endfunction

endpackage

[src/olt_req_if.sv]
// ----------------------------------------------------------------------------
// olt_req_if
// Input channel of the order lifecycle table.
// ----------------------------------------------------------------------------
interface olt_req_if;
	logic               valid;
	logic               ready;
	logic [3:0]         command;
	logic [31:0]        order_id;
	logic [31:0]        new_order_id;
	logic [31:0]        exchange_ref;
	logic [31:0]        instrument;
	logic               buy_sell;
	logic signed [31:0] limit_price;
	logic [31:0]        amount;
	logic [31:0]        left_amount;
	logic [7:0]         order_attrs;
	logic [3:0]         reason_in;
	logic               send_ok;

	modport source (output valid, command, order_id, new_order_id, exchange_ref,
		instrument, buy_sell, limit_price, amount, left_amount, order_attrs,
		reason_in, send_ok, input ready);
	modport sink (input valid, command, order_id, new_order_id, exchange_ref,
		instrument, buy_sell, limit_price, amount, left_amount, order_attrs,
		reason_in, send_ok, output ready);
endinterface

[src/olt_rsp_if.sv]
// ----------------------------------------------------------------------------
// olt_rsp_if
// Result channel of the order lifecycle table.
// ----------------------------------------------------------------------------
interface olt_rsp_if;
	logic               valid;
	logic               ready;
	logic [2:0]         kind;
	logic [31:0]        out_order_id;
	logic [2:0]         order_state;
	logic [1:0]         pending;
	logic [31:0]        out_exchange_ref;
	logic [31:0]        out_instrument;
	logic               out_side;
	logic signed [31:0] out_price;
	logic [31:0]        out_amount;
	logic [31:0]        out_left;
	logic [3:0]         last_reason;
	logic               last;

	modport source (output valid, kind, out_order_id, order_state, pending,
		out_exchange_ref, out_instrument, out_side, out_price, out_amount,
		out_left, last_reason, last, input ready);
	modport sink (input valid, kind, out_order_id, order_state, pending,
		out_exchange_ref, out_instrument, out_side, out_price, out_amount,
		out_left, last_reason, last, output ready);
endinterface

[src/order_lifecycle_table.sv]
// ----------------------------------------------------------------------------
// order_lifecycle_table
// Client order tracker: one table RAM entry per order id slot, updated by
// client commands and exchange events with a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// After reset every table entry is swept clear and no transaction is
// taken until the sweep ends; configuration writes work at any time. One
// transaction is handled at a time: the accept cycle also launches the table
// read, the next cycle modifies and writes the entry back, replace adds a
// second write of the new entry and replaced an update of its second entry,
// then the results are sent out while the sink is ready.
module order_lifecycle_table (
	input  logic       clk,
	input  logic       arst_n,
	olt_req_if.sink    req,
	olt_rsp_if.source  rsp,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);
	import olt_pkg::*;

	fsm_t             state_q, state_n;
	logic [IDX_W-1:0] clr_q;
	logic [31:0]      next_id_q, next_id_n;
	logic             fill_en_q, upd_en_q;
	logic [3:0]       err_code_q;
	req_t             req_q, req_in;
	res_t             res_q [2];
	res_t             res_n [2];
	logic [1:0]       cnt_q, cnt_n;
	logic             idx_q, idx_n;
	entry_t           fwd_q, fwd_n;
	logic             fwd_vld_q, fwd_vld_n;
	entry_t           ne_q, ne_n;

	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	entry_t           ram_wdata, ram_rdata;
	logic [ENTRY_W-1:0] ram_rbits;

	entry_t e, e2;
	logic   found, eligible;
	res_t   fill_r, cur_r;

	assign ram_rdata = entry_t'(ram_rbits);

	olt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rbits)
	);

	assign req_in = '{command: req.command, order_id: req.order_id,
		new_order_id: req.new_order_id, exchange_ref: req.exchange_ref,
		instrument: req.instrument, buy_sell: req.buy_sell,
		limit_price: req.limit_price, amount: req.amount,
		left_amount: req.left_amount, order_attrs: req.order_attrs,
		reason_in: req.reason_in, send_ok: req.send_ok};

	assign req.ready = (state_q == FSM_IDLE);

	assign cur_r                = res_q[idx_q];
	assign rsp.valid            = (state_q == FSM_OUT);
	assign rsp.kind             = cur_r.kind;
	assign rsp.out_order_id     = cur_r.order_id;
	assign rsp.order_state      = cur_r.order_state;
	assign rsp.pending          = cur_r.pending;
	assign rsp.out_exchange_ref = cur_r.exchange_ref;
	assign rsp.out_instrument   = cur_r.instrument;
	assign rsp.out_side         = cur_r.side;
	assign rsp.out_price        = cur_r.price;
	assign rsp.out_amount       = cur_r.amount;
	assign rsp.out_left         = cur_r.left;
	assign rsp.last_reason      = cur_r.last_reason;
	assign rsp.last             = ({1'b0, idx_q} == (cnt_q - 2'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= FSM_CLEAR;
			clr_q      <= '0;
			next_id_q  <= 32'd1;
			fill_en_q  <= 1'b1;
			upd_en_q   <= 1'b1;
			err_code_q <= 4'd15;
			cnt_q      <= '0;
			idx_q      <= 1'b0;
			fwd_vld_q  <= 1'b0;
		end else begin
			state_q   <= state_n;
			next_id_q <= next_id_n;
			cnt_q     <= cnt_n;
			idx_q     <= idx_n;
			fwd_vld_q <= fwd_vld_n;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FILL_EN:   fill_en_q  <= cfg_data[0];
					CFG_UPDATE_EN: upd_en_q   <= cfg_data[0];
					CFG_ERR_CODE:  err_code_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_q <= req_in;
		end
		res_q <= res_n;
		fwd_q <= fwd_n;
		ne_q  <= ne_n;
	end

	always_comb begin
		state_n   = state_q;
		next_id_n = next_id_q;
		res_n     = res_q;
		cnt_n     = cnt_q;
		idx_n     = idx_q;
		fwd_n     = fwd_q;
		fwd_vld_n = fwd_vld_q;
		ne_n      = ne_q;
		ram_we    = 1'b0;
		ram_waddr = req_q.order_id[IDX_W-1:0];
		ram_wdata = '0;
		ram_raddr = req_in.order_id[IDX_W-1:0];
		e         = ram_rdata;
		e2        = (fwd_vld_q && fwd_q.tag[IDX_W-1:0] == req_q.new_order_id[IDX_W-1:0])
			? fwd_q : ram_rdata;
		found     = e.valid && (e.tag == req_q.order_id);
		eligible  = found && (e.status == ST_LIVE || e.status == ST_PARTFILLED)
			&& (e.pending == PEND_NONE);
		fill_r    = '0;

		unique case (state_q)
			FSM_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
					state_n = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (req.valid) begin
					cnt_n     = '0;
					idx_n     = 1'b0;
					fwd_vld_n = 1'b0;
					state_n   = FSM_EXEC;
				end
			end
			FSM_EXEC: begin
				ram_raddr = req_q.new_order_id[IDX_W-1:0];
				state_n   = FSM_OUT;
				unique case (req_q.command)
					CMD_SUBMIT: begin
						next_id_n = next_id_q + 32'd1;
						ram_wdata = mk_new(next_id_q, req_q.instrument, req_q.buy_sell,
							req_q.limit_price, req_q.amount, req_q.order_attrs);
						if (!req_q.send_ok) begin
							ram_wdata.status = ST_REJECTED;
							ram_wdata.reason = err_code_q;
						end
						ram_we    = 1'b1;
						ram_waddr = next_id_q[IDX_W-1:0];
						if (!req_q.send_ok && upd_en_q) begin
							res_n[0] = mk_entry(KIND_UPDATE, ram_wdata);
							res_n[1] = mk_short(KIND_OK, next_id_q);
							cnt_n    = 2'd2;
						end else begin
							res_n[0] = mk_short(KIND_OK, next_id_q);
							cnt_n    = 2'd1;
						end
					end
					CMD_CANCEL: begin
						cnt_n = 2'd1;
						if (eligible && req_q.send_ok) begin
							ram_wdata         = e;
							ram_wdata.pending = PEND_CANCEL;
							ram_we            = 1'b1;
							res_n[0]          = mk_short(KIND_OK, req_q.order_id);
						end else begin
							res_n[0] = mk_short(KIND_REFUSED, req_q.order_id);
						end
					end
					CMD_REPLACE: begin
						cnt_n = 2'd1;
						if (!eligible) begin
							res_n[0] = mk_short(KIND_REFUSED, req_q.order_id);
						end else begin
							next_id_n = next_id_q + 32'd1;
							if (req_q.send_ok) begin
								ram_wdata         = e;
								ram_wdata.pending = PEND_REPLACE;
								ram_we            = 1'b1;
								ne_n     = mk_new(next_id_q, e.instr, e.side,
									req_q.limit_price, req_q.amount, e.attrs);
								res_n[0] = mk_short(KIND_OK, next_id_q);
								state_n  = FSM_REPL_WR;
							end else begin
								res_n[0] = mk_short(KIND_REFUSED, req_q.order_id);
							end
						end
					end
					CMD_ACCEPTED, CMD_REJECTED, CMD_CANCELLED, CMD_REPLACED,
					CMD_TRADE: begin
						ram_wdata = e;
						unique case (req_q.command)
							CMD_ACCEPTED: begin
								ram_wdata.xref   = req_q.exchange_ref;
								ram_wdata.status = ST_LIVE;
								ram_wdata.amount = req_q.amount;
								ram_wdata.left   = req_q.amount;
							end
							CMD_REJECTED: begin
								if (e.status == ST_PENDINGNEW) begin
									ram_wdata.status = ST_REJECTED;
								end
								ram_wdata.pending = PEND_NONE;
								ram_wdata.reason  = req_q.reason_in;
							end
							CMD_CANCELLED: begin
								ram_wdata.status  = ST_CANCELLED;
								ram_wdata.pending = PEND_NONE;
							end
							CMD_REPLACED: begin
								ram_wdata.status  = ST_REPLACED;
								ram_wdata.pending = PEND_NONE;
							end
							default: begin
								ram_wdata.left   = req_q.left_amount;
								ram_wdata.status = (req_q.left_amount == 32'd0)
									? ST_FILLED : ST_PARTFILLED;
							end
						endcase
						fill_r            = mk_entry(KIND_FILL, ram_wdata);
						fill_r.order_id   = req_q.order_id;
						fill_r.instrument = req_q.instrument;
						fill_r.price      = req_q.limit_price;
						fill_r.amount     = req_q.amount;
						if (found) begin
							ram_we = 1'b1;
							if (upd_en_q) begin
								res_n[0] = mk_entry(KIND_UPDATE, ram_wdata);
								cnt_n    = 2'd1;
							end
							if (req_q.command == CMD_TRADE && fill_en_q) begin
								res_n[cnt_n[0]] = fill_r;
								cnt_n           = cnt_n + 2'd1;
							end
						end
						fwd_n     = ram_wdata;
						fwd_vld_n = found;
						if (req_q.command == CMD_REPLACED) begin
							state_n = FSM_EXEC2;
						end else if (!found || cnt_n == 2'd0) begin
							state_n = FSM_IDLE;
						end
					end
					CMD_QUERY: begin
						cnt_n    = 2'd1;
						res_n[0] = found ? mk_entry(KIND_FOUND, e)
							: mk_short(KIND_MISSING, req_q.order_id);
					end
					default: begin
						state_n = FSM_IDLE;
					end
				endcase
			end
			FSM_EXEC2: begin
				ram_wdata        = e2;
				ram_wdata.status = ST_LIVE;
				ram_wdata.xref   = req_q.exchange_ref;
				ram_wdata.price  = req_q.limit_price;
				ram_wdata.amount = req_q.amount;
				ram_wdata.left   = req_q.amount;
				ram_waddr        = req_q.new_order_id[IDX_W-1:0];
				if (e2.valid && e2.tag == req_q.new_order_id) begin
					ram_we = 1'b1;
					if (upd_en_q) begin
						res_n[cnt_n[0]] = mk_entry(KIND_UPDATE, ram_wdata);
						cnt_n           = cnt_n + 2'd1;
					end
				end
				state_n = (cnt_n == 2'd0) ? FSM_IDLE : FSM_OUT;
			end
			FSM_REPL_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ne_q.tag[IDX_W-1:0];
				ram_wdata = ne_q;
				state_n   = FSM_OUT;
			end
			FSM_OUT: begin
				if (rsp.ready) begin
					if (rsp.last) begin
						state_n = FSM_IDLE;
					end else begin
						idx_n = 1'b1;
					end
				end
			end
			default: begin
				state_n = FSM_IDLE;
			end
		endcase
	end
endmodule

[src/olt_ram.sv]
// ----------------------------------------------------------------------------
// olt_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module olt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[dv/olt_tb_if.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// olt_tb_if
// Bench-side types: the result record that the checker compares field by field.
// ----------------------------------------------------------------------------
package olt_tb_pkg;
	import olt_pkg::*;

	typedef struct packed {
		logic [2:0]  kind;
		logic [31:0] oid;
		logic [2:0]  st;
		logic [1:0]  pend;
		logic [31:0] xref;
		logic [31:0] instr;
		logic        side;
		logic [31:0] price;
		logic [31:0] amount;
		logic [31:0] left;
		logic [3:0]  reason;
		logic        last;
	} outcome_t;
endpackage

[dv/order_lifecycle_table_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// order_lifecycle_table_tb
// Drives client commands and exchange events into the order table, keeps a
// shadow copy of the table, and checks every result field by field in order.
// ----------------------------------------------------------------------------
module order_lifecycle_table_tb;
	import olt_pkg::*;
	import olt_tb_pkg::*;

	localparam int WATCHDOG = 20000;
	localparam int N_ROWS   = 25;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	olt_req_if req();
	olt_rsp_if rsp();

	order_lifecycle_table dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow table
	logic        sh_valid  [TABLE_DEPTH];
	logic [31:0] sh_tag    [TABLE_DEPTH];
	logic [31:0] sh_xref   [TABLE_DEPTH];
	logic [31:0] sh_instr  [TABLE_DEPTH];
	logic        sh_side   [TABLE_DEPTH];
	logic [31:0] sh_price  [TABLE_DEPTH];
	logic [31:0] sh_amount [TABLE_DEPTH];
	logic [31:0] sh_left   [TABLE_DEPTH];
	logic [7:0]  sh_attrs  [TABLE_DEPTH];
	logic [2:0]  sh_status [TABLE_DEPTH];
	logic [1:0]  sh_pend   [TABLE_DEPTH];
	logic [3:0]  sh_reason [TABLE_DEPTH];
	logic [31:0] sh_next_id;
	logic        fill_en, update_en;
	logic [3:0]  err_code;

	outcome_t expected_q[$];
	req_t     stim_q[$];
	int       errors = 0;
	int       n_results = 0;
	int       n_sent = 0;
	int       idle_cycles = 0;
	bit       long_stall = 1'b0;
	int       kind_seen[8];

	typedef struct {
		cmd_t        cmd;
		logic [31:0] id;
		logic        ok;
		logic [31:0] left;
		bit          typed;
		kind_t       ekind;
		logic [31:0] eid;
	} row_t;

	row_t plan[N_ROWS] = '{
		'{CMD_QUERY,     32'd1,         1'b1, 32'd0, 1'b1, KIND_MISSING, 32'd1},
		'{CMD_CANCEL,    32'hFFFF_FFFF, 1'b1, 32'd0, 1'b1, KIND_REFUSED, 32'hFFFF_FFFF},
		'{CMD_REPLACE,   32'd0,         1'b1, 32'd0, 1'b1, KIND_REFUSED, 32'd0},
		'{CMD_SUBMIT,    32'd0,         1'b1, 32'd0, 1'b1, KIND_OK,      32'd1},
		'{CMD_SUBMIT,    32'd0,         1'b0, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_CANCEL,    32'd1,         1'b1, 32'd0, 1'b1, KIND_REFUSED, 32'd1},
		'{CMD_ACCEPTED,  32'd1,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_TRADE,     32'd1,         1'b1, 32'd5, 1'b0, KIND_OK,      32'd0},
		'{CMD_REPLACE,   32'd1,         1'b0, 32'd0, 1'b1, KIND_REFUSED, 32'd1},
		'{CMD_REPLACE,   32'd1,         1'b1, 32'd0, 1'b1, KIND_OK,      32'd4},
		'{CMD_CANCEL,    32'd1,         1'b1, 32'd0, 1'b1, KIND_REFUSED, 32'd1},
		'{CMD_REPLACED,  32'd1,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_CANCEL,    32'd4,         1'b0, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_CANCEL,    32'd4,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_CANCELLED, 32'd4,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_REJECTED,  32'd2,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_SUBMIT,    32'd0,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_REJECTED,  32'd5,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_SUBMIT,    32'd0,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_ACCEPTED,  32'd6,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_TRADE,     32'd6,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_QUERY,     32'd6,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_QUERY,     32'd1030,      1'b1, 32'd0, 1'b1, KIND_MISSING, 32'd1030},
		'{cmd_t'(4'd15), 32'd6,         1'b1, 32'd0, 1'b0, KIND_OK,      32'd0},
		'{CMD_ACCEPTED,  32'd999,       1'b1, 32'd0, 1'b0, KIND_OK,      32'd0}
	};

	function automatic int slot(input logic [31:0] id);
		return int'(id % TABLE_DEPTH);
	endfunction

	function automatic bit known(input logic [31:0] id);
		return sh_valid[slot(id)] && sh_tag[slot(id)] == id;
	endfunction

	function automatic outcome_t brief(input kind_t k, input logic [31:0] id);
		outcome_t o;
		o = '0;
		o.kind = k;
		o.oid = id;
		return o;
	endfunction

	function automatic outcome_t snapshot(input kind_t k, input int s);
		outcome_t o;
		o = '{kind: k, oid: sh_tag[s], st: sh_status[s], pend: sh_pend[s],
			xref: sh_xref[s], instr: sh_instr[s], side: sh_side[s],
			price: sh_price[s], amount: sh_amount[s], left: sh_left[s],
			reason: sh_reason[s], last: 1'b0};
		return o;
	endfunction

	function automatic void open_order(input logic [31:0] id, input logic [31:0] instr,
		input logic side, input logic [31:0] price, input logic [31:0] qty,
		input logic [7:0] attrs);
		int s;
		s = slot(id);
		sh_valid[s] = 1'b1; sh_tag[s] = id; sh_xref[s] = '0; sh_instr[s] = instr;
		sh_side[s] = side; sh_price[s] = price; sh_amount[s] = qty; sh_left[s] = qty;
		sh_attrs[s] = attrs; sh_status[s] = ST_PENDINGNEW; sh_pend[s] = PEND_NONE;
		sh_reason[s] = '0;
	endfunction

	function automatic bit can_amend(input logic [31:0] id);
		int s;
		s = slot(id);
		return known(id) && (sh_status[s] == ST_LIVE || sh_status[s] == ST_PARTFILLED)
			&& sh_pend[s] == PEND_NONE;
	endfunction

	function automatic void predict_lifecycle(input req_t r);
		outcome_t res[$];
		logic [31:0] nid;
		int s, s2;
		s = slot(r.order_id);
		case (r.command)
			CMD_SUBMIT: begin
				nid = sh_next_id;
				sh_next_id = sh_next_id + 1;
				open_order(nid, r.instrument, r.buy_sell, r.limit_price, r.amount,
					r.order_attrs);
				if (!r.send_ok) begin
					s = slot(nid);
					sh_status[s] = ST_REJECTED;
					sh_pend[s] = PEND_NONE;
					sh_reason[s] = err_code;
					if (update_en) res.insert(res.size(), snapshot(KIND_UPDATE, s));
				end
				res.insert(res.size(), brief(KIND_OK, nid));
			end
			CMD_CANCEL: begin
				if (can_amend(r.order_id) && r.send_ok) begin
					sh_pend[s] = PEND_CANCEL;
					res.insert(res.size(), brief(KIND_OK, r.order_id));
				end else res.insert(res.size(), brief(KIND_REFUSED, r.order_id));
			end
			CMD_REPLACE: begin
				if (!can_amend(r.order_id))
					res.insert(res.size(), brief(KIND_REFUSED, r.order_id));
				else begin
					nid = sh_next_id;
					sh_next_id = sh_next_id + 1;
					if (r.send_ok) begin
						sh_pend[s] = PEND_REPLACE;
						open_order(nid, sh_instr[s], sh_side[s], r.limit_price, r.amount,
							sh_attrs[s]);
						res.insert(res.size(), brief(KIND_OK, nid));
					end else res.insert(res.size(), brief(KIND_REFUSED, r.order_id));
				end
			end
			CMD_ACCEPTED: if (known(r.order_id)) begin
				sh_xref[s] = r.exchange_ref; sh_status[s] = ST_LIVE;
				sh_amount[s] = r.amount; sh_left[s] = r.amount;
				if (update_en) res.insert(res.size(), snapshot(KIND_UPDATE, s));
			end
			CMD_REJECTED: if (known(r.order_id)) begin
				if (sh_status[s] == ST_PENDINGNEW) sh_status[s] = ST_REJECTED;
				sh_pend[s] = PEND_NONE; sh_reason[s] = r.reason_in;
				if (update_en) res.insert(res.size(), snapshot(KIND_UPDATE, s));
			end
			CMD_CANCELLED: if (known(r.order_id)) begin
				sh_status[s] = ST_CANCELLED; sh_pend[s] = PEND_NONE;
				if (update_en) res.insert(res.size(), snapshot(KIND_UPDATE, s));
			end
			CMD_REPLACED: begin
				if (known(r.order_id)) begin
					sh_status[s] = ST_REPLACED; sh_pend[s] = PEND_NONE;
					if (update_en) res.insert(res.size(), snapshot(KIND_UPDATE, s));
				end
				if (known(r.new_order_id)) begin
					s2 = slot(r.new_order_id);
					sh_status[s2] = ST_LIVE; sh_xref[s2] = r.exchange_ref;
					sh_price[s2] = r.limit_price; sh_amount[s2] = r.amount;
					sh_left[s2] = r.amount;
					if (update_en) res.insert(res.size(), snapshot(KIND_UPDATE, s2));
				end
			end
			CMD_TRADE: if (known(r.order_id)) begin
				sh_left[s] = r.left_amount;
				sh_status[s] = (r.left_amount == 0) ? ST_FILLED : ST_PARTFILLED;
				if (update_en) res.insert(res.size(), snapshot(KIND_UPDATE, s));
				if (fill_en) begin
					res.insert(res.size(), snapshot(KIND_FILL, s));
					res[$].oid = r.order_id; res[$].instr = r.instrument;
					res[$].price = r.limit_price; res[$].amount = r.amount;
				end
			end
			CMD_QUERY: begin
				if (known(r.order_id)) res.insert(res.size(), snapshot(KIND_FOUND, s));
				else res.insert(res.size(), brief(KIND_MISSING, r.order_id));
			end
			default: ;
		endcase
		if (res.size() > 0) res[$].last = 1'b1;
		foreach (res[i]) expected_q.insert(expected_q.size(), res[i]);
	endfunction

	// typed rows of the directed table: hold the prediction to the typed value
	function automatic void check_row(input int i);
		outcome_t o;
		o = '0;
		if (expected_q.size() > 0) o = expected_q[$];
		if (plan[i].typed && (o.kind !== plan[i].ekind || o.oid !== plan[i].eid)) begin
			errors++;
			$display("%0t: directed row %0d, expected %0d/%0d, actual %0d/%0d",
				$time, i, plan[i].ekind, plan[i].eid, o.kind, o.oid);
		end
	endfunction

	function automatic req_t make_req(input cmd_t c, input logic [31:0] id,
		input logic [31:0] nid, input logic ok);
		req_t r;
		r = '{command: c, order_id: id, new_order_id: nid, exchange_ref: $urandom,
			instrument: $urandom, buy_sell: 1'($urandom_range(0, 1)),
			limit_price: $urandom, amount: $urandom, left_amount: $urandom,
			order_attrs: 8'($urandom), reason_in: 4'($urandom), send_ok: ok};
		return r;
	endfunction

	// mostly recent issued ids, to hit real orders; else slot aliases or random
	function automatic logic [31:0] pick_id();
		int k;
		k = $urandom_range(0, 99);
		if (k < 80) return sh_next_id - 1 - $urandom_range(0, 12);
		if (k < 90) return sh_next_id + TABLE_DEPTH * $urandom_range(1, 3) - 2;
		return $urandom;
	endfunction

	// sender: bursts and gaps
	task automatic send_all();
		int burst;
		req_t r;
		while (stim_q.size() > 0) begin
			burst = $urandom_range(1, 12);
			while (burst > 0 && stim_q.size() > 0) begin
				r = stim_q.pop_front();
				req.valid <= 1'b1;
				{req.command, req.order_id, req.new_order_id, req.exchange_ref,
					req.instrument, req.buy_sell, req.limit_price, req.amount,
					req.left_amount, req.order_attrs, req.reason_in, req.send_ok} <= r;
				@(posedge clk);
				while (!req.ready) @(posedge clk);
				predict_lifecycle(r);
				if (n_sent < N_ROWS) check_row(n_sent);
				n_sent++;
				burst--;
			end
			if ($urandom_range(0, 2) != 0) begin
				req.valid <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		req.valid <= 1'b0;
	endtask

	task automatic drain();
		while (expected_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_reg(input cfg_idx_t idx, input logic [3:0] v);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_FILL_EN:   fill_en = v[0];
			CFG_UPDATE_EN: update_en = v[0];
			default:       err_code = v;
		endcase
	endtask

	// receiver: stall pattern, one long hold-off
	always @(posedge clk) begin
		if (long_stall) rsp.ready <= 1'b0;
		else rsp.ready <= ($urandom_range(0, 7) < 5) || (n_sent % 200 < 40);
	end

	always @(posedge clk) begin
		outcome_t a, e;
		if (arst_n && rsp.valid && rsp.ready) begin
			a = '{kind: rsp.kind, oid: rsp.out_order_id, st: rsp.order_state,
				pend: rsp.pending, xref: rsp.out_exchange_ref, instr: rsp.out_instrument,
				side: rsp.out_side, price: rsp.out_price, amount: rsp.out_amount,
				left: rsp.out_left, reason: rsp.last_reason, last: rsp.last};
			n_results++;
			kind_seen[a.kind]++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, actual %p", $time, a);
			end else begin
				e = expected_q.pop_front();
				if (a !== e) begin
					errors++;
					$display("%0t: result mismatch, expected %p, actual %p", $time, e, a);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("%0t: watchdog expired, %0d results pending", $time, expected_q.size());
			$display("order_lifecycle_table_tb: done, errors");
			$finish;
		end
	end

	task automatic load_random(input int count);
		int k;
		logic [31:0] id;
		repeat (count) begin
			k = $urandom_range(0, 99);
			id = pick_id();
			if (k < 18) stim_q.insert(stim_q.size(),
				make_req(CMD_SUBMIT, 0, 0, $urandom_range(0, 9) != 0));
			else if (k < 28) stim_q.insert(stim_q.size(),
				make_req(CMD_ACCEPTED, id, 0, 1'b1));
			else if (k < 36) stim_q.insert(stim_q.size(),
				make_req(CMD_CANCEL, id, 0, $urandom_range(0, 4) != 0));
			else if (k < 46) stim_q.insert(stim_q.size(),
				make_req(CMD_REPLACE, id, 0, $urandom_range(0, 4) != 0));
			else if (k < 51) stim_q.insert(stim_q.size(),
				make_req(CMD_REJECTED, id, 0, 1'b1));
			else if (k < 57) stim_q.insert(stim_q.size(),
				make_req(CMD_CANCELLED, id, 0, 1'b1));
			else if (k < 66) stim_q.insert(stim_q.size(), make_req(CMD_REPLACED, id,
				($urandom_range(0, 5) == 0) ? id : pick_id(), 1'b1));
			else if (k < 80) begin
				stim_q.insert(stim_q.size(), make_req(CMD_TRADE, id, 0, 1'b1));
				if ($urandom_range(0, 3) == 0) stim_q[$].left_amount = 0;
			end else if (k < 97) stim_q.insert(stim_q.size(),
				make_req(CMD_QUERY, id, 0, 1'b1));
			else stim_q.insert(stim_q.size(),
				make_req(cmd_t'(4'($urandom_range(9, 15))), id, 0, 1'b1));
		end
	endtask

	initial begin
		req_t r;
		int phase;
		arst_n <= 1'b0;
		foreach (sh_valid[i]) sh_valid[i] = 1'b0;
		sh_next_id = 1;
		fill_en = 1'b1; update_en = 1'b1; err_code = 4'd15;
		req.valid = 1'b0;
		{req.command, req.order_id, req.new_order_id, req.exchange_ref, req.instrument,
			req.buy_sell, req.limit_price, req.amount, req.left_amount, req.order_attrs,
			req.reason_in, req.send_ok} = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed table; the replaced row carries the new id of the replace
		foreach (plan[i]) begin
			r = make_req(plan[i].cmd, plan[i].id, 32'd4, plan[i].ok);
			if (plan[i].cmd == CMD_TRADE) r.left_amount = plan[i].left;
			if (i == 0) begin
				r.exchange_ref = '1; r.instrument = '1; r.limit_price = 32'h8000_0000;
				r.amount = '1; r.order_attrs = '1; r.buy_sell = 1'b1;
			end
			stim_q.insert(stim_q.size(), r);
		end
		send_all();
		drain();

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin set_reg(CFG_FILL_EN, 4'd0); set_reg(CFG_ERR_CODE, 4'd0); end
				2: begin set_reg(CFG_UPDATE_EN, 4'd0); set_reg(CFG_FILL_EN, 4'd1); end
				3: begin set_reg(CFG_ERR_CODE, 4'd15); set_reg(CFG_UPDATE_EN, 4'd1); end
				4: begin set_reg(CFG_FILL_EN, 4'd0); set_reg(CFG_UPDATE_EN, 4'd0);
					set_reg(CFG_ERR_CODE, 4'd7); end
				5: begin set_reg(CFG_FILL_EN, 4'd1); set_reg(CFG_UPDATE_EN, 4'd1); end
				default: ;
			endcase
			load_random(230);
			fork
				send_all();
				if (phase == 2) begin
					repeat (50) @(posedge clk);
					long_stall = 1'b1;
					repeat (300) @(posedge clk);
					long_stall = 1'b0;
				end
			join
			drain();
		end

		$display("Sent %0d transactions, checked %0d results (ok %0d, refused %0d,",
			n_sent, n_results, kind_seen[KIND_OK], kind_seen[KIND_REFUSED]);
		$display("  update %0d, fill %0d, found %0d, missing %0d) over 6 settings",
			kind_seen[KIND_UPDATE], kind_seen[KIND_FILL], kind_seen[KIND_FOUND],
			kind_seen[KIND_MISSING]);
		if (errors == 0 && expected_q.size() == 0) begin
			$display("order_lifecycle_table_tb: done, clean");
		end else begin
			$display("order_lifecycle_table_tb: done, errors");
		end
		$finish;
	end
endmodule

[sim.f]
src/olt_pkg.sv
src/olt_req_if.sv
src/olt_rsp_if.sv
src/olt_ram.sv
src/order_lifecycle_table.sv
dv/olt_tb_if.sv
dv/order_lifecycle_table_tb.sv
